// File: hdl/pxsc_pkg.sv
// Shared constants, types and key helpers for the packet XOR stream cipher.
package pxsc_pkg;

   localparam int unsigned POS_W       = 17;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned PHASE_W     = 4;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned KEY_LOW_W   = 64;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [POS_W-1:0]   DATA_START = POS_W'(5);
   localparam logic [POS_W-1:0]   POS_MAX    = {POS_W{1'b1}};
   localparam logic [PHASE_W-1:0] KEY_LAST   = PHASE_W'(8);

   // Header offsets
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SEQ    = POS_W'(4);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_BUILTIN_KEY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES_LOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTE_LAST   = 2'd2;

   typedef struct packed {
      logic               data_en;
      logic [PHASE_W-1:0] phase;
      logic [BYTE_W-1:0]  group;
      logic [BYTE_W-1:0]  seq;
   } track_type;

   typedef struct packed {
      logic                 use_builtin;
      logic [KEY_LOW_W-1:0] key_low;
      logic [BYTE_W-1:0]    key_last;
   } key_cfg_type;

   // Fixed nine-byte key "Urk#nI7ni"
   function automatic logic [BYTE_W-1:0] builtin_key(input logic [PHASE_W-1:0] k);
      logic [BYTE_W-1:0] b;
      case (k)
         4'd0:    b = 8'h55;
         4'd1:    b = 8'h72;
         4'd2:    b = 8'h6B;
         4'd3:    b = 8'h23;
         4'd4:    b = 8'h6E;
         4'd5:    b = 8'h49;
         4'd6:    b = 8'h37;
         4'd7:    b = 8'h6E;
         4'd8:    b = 8'h69;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: hdl/pxsc_tracker.sv
// Packet position tracking: header capture, data window, key phase and group.
module pxsc_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [pxsc_pkg::BYTE_W-1:0]   byte_in,
   input  logic                          end_of_packet,
   output pxsc_pkg::track_type           track
);

   logic [pxsc_pkg::POS_W-1:0]   position_ff, position_in;
   logic [pxsc_pkg::LEN_W-1:0]   length_ff, length_in;
   logic [pxsc_pkg::BYTE_W-1:0]  seq_ff, seq_in;
   logic [pxsc_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [pxsc_pkg::BYTE_W-1:0]  group_ff, group_in;
   logic                         data_en;

   assign data_en = (position_ff >= pxsc_pkg::DATA_START) &&
                    (position_ff < {1'b0, length_ff});

   assign track.data_en = data_en;
   assign track.phase   = phase_ff;
   assign track.group   = group_ff;
   assign track.seq     = seq_ff;

   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      seq_in      = seq_ff;
      phase_in    = phase_ff;
      group_in    = group_ff;
      if (fire) begin
         if (position_ff == pxsc_pkg::POS_LEN_HI) begin
            length_in = {byte_in, length_ff[7:0]};
         end else if (position_ff == pxsc_pkg::POS_LEN_LO) begin
            length_in = {length_ff[15:8], byte_in};
         end else if (position_ff == pxsc_pkg::POS_SEQ) begin
            seq_in = byte_in;
         end else if (data_en) begin
            if (phase_ff == pxsc_pkg::KEY_LAST) begin
               phase_in = '0;
               group_in = group_ff + 8'd1;
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end
         if (end_of_packet) begin
            position_in = '0;
            phase_in    = '0;
            group_in    = '0;
         end else if (position_ff != pxsc_pkg::POS_MAX) begin
            position_in = position_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         length_ff   <= '0;
         seq_ff      <= '0;
         phase_ff    <= '0;
         group_ff    <= '0;
      end else begin
         position_ff <= position_in;
         length_ff   <= length_in;
         seq_ff      <= seq_in;
         phase_ff    <= phase_in;
         group_ff    <= group_in;
      end
   end

endmodule

// File: hdl/pxsc_keystream.sv
// Key byte selection and the XOR applied to one data byte.
module pxsc_keystream (
   input  pxsc_pkg::track_type           track,
   input  pxsc_pkg::key_cfg_type         key_cfg,
   input  logic [pxsc_pkg::BYTE_W-1:0]   byte_in,
   output logic [pxsc_pkg::BYTE_W-1:0]   byte_out,
   output logic                          was_ciphered
);

   logic [pxsc_pkg::BYTE_W-1:0] key_byte;
   logic [pxsc_pkg::BYTE_W-1:0] group_term;

   always_comb begin
      if (key_cfg.use_builtin) begin
         key_byte = pxsc_pkg::builtin_key(track.phase);
      end else if (track.phase >= pxsc_pkg::KEY_LAST) begin
         key_byte = key_cfg.key_last;
      end else begin
         key_byte = key_cfg.key_low[{track.phase[2:0], 3'b000} +: 8];
      end
   end

   // Skip the group number when it matches the sequence byte
   assign group_term = (track.group != track.seq) ? track.group : '0;

   assign byte_out     = track.data_en ? (byte_in ^ key_byte ^ group_term ^ track.seq)
                                       : byte_in;
   assign was_ciphered = track.data_en;

endmodule

// File: hdl/packet_xor_stream_cipher_unit.sv
// Top level of the packet XOR stream cipher: key registers, tracker and result register.
// Usage:
//   Send packet bytes in order on the request channel (req_valid/req_ready,
//   req_byte_in, req_end_of_packet marking the last byte). Each request gives
//   exactly one response (rsp_valid/rsp_ready) carrying the byte, ciphered or
//   passed through, plus was_ciphered and a copy of the end-of-packet flag.
//   Byte 0 is the header, bytes 1-2 the big-endian length L, byte 4 the
//   sequence byte; bytes at offsets 5..L-1 are XORed with the key stream.
// Latency and throughput:
//   rsp_valid rises the cycle after a request is accepted. One byte per cycle
//   while rsp_ready is high, set by the single result register; the position,
//   phase and group counters update in the same cycle the request is accepted.
// Reset:
//   Synchronous, active high: built-in key selected, key, tracker and valid state cleared; result data not reset.
// Stall:
//   The result register holds a byte while rsp_ready is low; req_ready stays
//   high whenever the register is empty or is being drained this cycle.
// Configuration:
//   csr_write_en writes csr_write_data to register csr_index (0 built-in key
//   select, 1 key bytes 0-7, 2 key byte 8); other indexes are dropped.
module packet_xor_stream_cipher_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pxsc_pkg::BYTE_W-1:0]         req_byte_in,
   input  logic                                req_end_of_packet,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pxsc_pkg::BYTE_W-1:0]         rsp_byte_out,
   output logic                                rsp_was_ciphered,
   output logic                                rsp_last_out,
   input  logic                                csr_write_en,
   input  logic [pxsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pxsc_pkg::KEY_LOW_W-1:0]      csr_write_data
);

   pxsc_pkg::key_cfg_type         key_cfg_ff, key_cfg_in;
   pxsc_pkg::track_type           track;
   logic                          fire;
   logic [pxsc_pkg::BYTE_W-1:0]   cipher_byte;
   logic                          cipher_flag;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pxsc_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                          rsp_ciphered_ff, rsp_ciphered_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Accept whenever the result register is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   // Configuration registers
   always_comb begin
      key_cfg_in = key_cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pxsc_pkg::CSR_USE_BUILTIN_KEY: key_cfg_in.use_builtin = csr_write_data[0];
            pxsc_pkg::CSR_KEY_BYTES_LOW:   key_cfg_in.key_low     = csr_write_data;
            pxsc_pkg::CSR_KEY_BYTE_LAST:   key_cfg_in.key_last    = csr_write_data[7:0];
            default:                       key_cfg_in             = key_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cfg_ff.use_builtin <= 1'b1;
         key_cfg_ff.key_low     <= '0;
         key_cfg_ff.key_last    <= '0;
      end else begin
         key_cfg_ff <= key_cfg_in;
      end
   end

   pxsc_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .byte_in       (req_byte_in),
      .end_of_packet (req_end_of_packet),
      .track         (track)
   );

   pxsc_keystream u_keystream (
      .track        (track),
      .key_cfg      (key_cfg_ff),
      .byte_in      (req_byte_in),
      .byte_out     (cipher_byte),
      .was_ciphered (cipher_flag)
   );

   // Result register: load on accept, hold while stalled
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_ciphered_in = rsp_ciphered_ff;
      rsp_last_in     = rsp_last_ff;
      if (fire) begin
         rsp_valid_in    = 1'b1;
         rsp_byte_in     = cipher_byte;
         rsp_ciphered_in = cipher_flag;
         rsp_last_in     = req_end_of_packet;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff     <= rsp_byte_in;
      rsp_ciphered_ff <= rsp_ciphered_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_byte_ff;
   assign rsp_was_ciphered = rsp_ciphered_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule
